@@ design/soft_limit_velocity_integrator_unit_assert.svh @@
// Assertion macros used by the velocity integrator top level.
`ifndef SOFT_LIMIT_VELOCITY_INTEGRATOR_UNIT_ASSERT_SVH
`define SOFT_LIMIT_VELOCITY_INTEGRATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define SLVI_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("slvi same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define SLVI_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("slvi next-cycle check failed");

`endif

@@ design/slvi_pkg.sv @@
// Types and constants of the soft-limit velocity integrator.
`timescale 1ns / 1ps
`default_nettype none

package slvi_pkg;

  localparam int unsigned TICK_W = 6;
  localparam logic [TICK_W-1:0] TICK_SAT = '1;

  localparam int unsigned INCR_W = 23;
  localparam int unsigned ACC_STEP = 13107;
  localparam int unsigned TICK_DIV = 125;
  localparam logic signed [INCR_W-1:0] INCR_STEP = INCR_W'(ACC_STEP / TICK_DIV);

  localparam logic [31:0] HUMAN_DIV = 32'd5;
  localparam logic [31:0] DIV625_MUL = 32'd3518437209;
  localparam int unsigned DIV625_SHIFT = 41;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_ACTION  = 3'd1,
    OP_HUMAN   = 3'd2,
    OP_TRAIN   = 3'd3,
    OP_RESTART = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_POS  = 2'd1,
    ACT_NEG  = 2'd2
  } act_t;

  typedef enum logic [2:0] {
    REG_VEL_FLOOR = 3'd0,
    REG_VEL_CEIL  = 3'd1,
    REG_X_LOWER   = 3'd2,
    REG_X_UPPER   = 3'd3,
    REG_Y_LOWER   = 3'd4,
    REG_Y_UPPER   = 3'd5
  } reg_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] position_x;
    logic signed [31:0] position_y;
    logic [1:0]         agent_action;
    logic signed [31:0] human_value;
    logic               train_on;
  } in_t;

  typedef struct packed {
    logic signed [31:0] velocity_x;
    logic signed [31:0] velocity_y;
    logic               stopped_x;
    logic               stopped_y;
  } out_t;

  typedef struct packed {
    logic               armed;
    logic signed [31:0] vel;
    logic               stop;
    logic [TICK_W-1:0]  ticks;
    logic signed [INCR_W-1:0] incr;
    logic               acc_pos;
    logic               acc_neg;
  } axis_st_t;

  typedef struct packed {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } limits_t;

  typedef struct packed {
    logic signed [31:0] floor_v;
    logic signed [31:0] ceil_v;
  } window_t;

endpackage

`default_nettype wire

@@ design/soft_limit_velocity_integrator_unit.sv @@
// Top level of the two-axis velocity integrator with soft position limits.
//
// Items enter on in_valid/in_ready and land in an input register. From there
// each item is executed combinationally against the axis state. Only a tick item
// makes a result, which is loaded into the output register and offered on
// out_valid/out_ready; all other items update state and are dropped.
// A tick item waits in the input register until the output register is free or
// being read, and its result is then loaded into the output register. Throughput
// is one item per cycle while no tick is held back by a stalled receiver.
// When the receiver stalls, the output register holds its result and the input
// register holds a waiting tick; non-tick items keep flowing behind a held
// result until a tick reaches the input register. in_ready then stays low.
// The configuration registers are written on cfg_we with cfg_index and
// cfg_wdata and must only be written while the block is idle.
// Synchronous reset clears the configuration registers and velocities to zero,
// disarms both axes, clears the stop latches, tick counters and train mode,
// and empties the input and output registers.
`timescale 1ns / 1ps
`default_nettype none

module soft_limit_velocity_integrator_unit #(
  parameter int ARM_TICKS = 50
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  slvi_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output slvi_pkg::out_t   out_data,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_wdata
);

  `include "soft_limit_velocity_integrator_unit_assert.svh"

  slvi_pkg::in_t      in_q_r;
  logic               in_q_valid_r;
  slvi_pkg::out_t     out_q_r;
  slvi_pkg::out_t     out_q_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;

  slvi_pkg::axis_st_t axis_x_r;
  slvi_pkg::axis_st_t axis_x_nxt;
  slvi_pkg::axis_st_t axis_y_r;
  slvi_pkg::axis_st_t axis_y_nxt;
  slvi_pkg::axis_st_t tick_x;
  slvi_pkg::axis_st_t tick_y;
  logic               train_mode_r;
  logic               train_mode_nxt;

  slvi_pkg::window_t  win_r;
  slvi_pkg::limits_t  lim_x_r;
  slvi_pkg::limits_t  lim_y_r;

  logic               is_tick;
  logic               proc_ok;

  logic [31:0]        hv_u;
  logic [31:0]        hv_mag;
  logic [63:0]        hv_prod;
  logic [slvi_pkg::INCR_W-1:0] hv_q;
  logic signed [slvi_pkg::INCR_W-1:0] hv_incr;
  logic               hv_big;

  assign is_tick  = in_q_r.operation == slvi_pkg::OP_TICK;
  assign proc_ok  = in_q_valid_r && (!is_tick || !out_valid_r || out_ready);
  assign in_ready = !in_q_valid_r || proc_ok;

  assign out_valid = out_valid_r;
  assign out_data  = out_q_r;

  // Human value scaled by 1/625 gives the per-tick Y increment directly.
  assign hv_u    = $unsigned(in_q_r.human_value);
  assign hv_mag  = in_q_r.human_value[31] ? (~hv_u + 32'd1) : hv_u;
  assign hv_prod = 64'(hv_mag) * 64'(slvi_pkg::DIV625_MUL);
  assign hv_q    = hv_prod[63:slvi_pkg::DIV625_SHIFT];
  assign hv_incr = in_q_r.human_value[31] ? -$signed(hv_q) : $signed(hv_q);
  assign hv_big  = hv_mag >= slvi_pkg::HUMAN_DIV;

  slvi_axis #(
    .ARM_TICKS(ARM_TICKS)
  ) u_axis_x (
    .st_i (axis_x_r),
    .pos  (in_q_r.position_x),
    .lim  (lim_x_r),
    .win  (win_r),
    .st_o (tick_x)
  );

  slvi_axis #(
    .ARM_TICKS(ARM_TICKS)
  ) u_axis_y (
    .st_i (axis_y_r),
    .pos  (in_q_r.position_y),
    .lim  (lim_y_r),
    .win  (win_r),
    .st_o (tick_y)
  );

  always_comb begin
    axis_x_nxt     = axis_x_r;
    axis_y_nxt     = axis_y_r;
    train_mode_nxt = train_mode_r;
    if (proc_ok) begin
      case (in_q_r.operation)
        slvi_pkg::OP_TICK: begin
          if (!train_mode_r) begin
            if (axis_x_r.armed) begin
              axis_x_nxt = tick_x;
            end
            if (axis_y_r.armed) begin
              axis_y_nxt = tick_y;
            end
          end
        end
        slvi_pkg::OP_ACTION: begin
          axis_x_nxt.armed = 1'b1;
          case (in_q_r.agent_action)
            slvi_pkg::ACT_POS: begin
              axis_x_nxt.incr    = slvi_pkg::INCR_STEP;
              axis_x_nxt.acc_pos = 1'b1;
              axis_x_nxt.acc_neg = 1'b0;
            end
            slvi_pkg::ACT_NEG: begin
              axis_x_nxt.incr    = -slvi_pkg::INCR_STEP;
              axis_x_nxt.acc_pos = 1'b0;
              axis_x_nxt.acc_neg = 1'b1;
            end
            default: begin
              axis_x_nxt.incr    = '0;
              axis_x_nxt.acc_pos = 1'b0;
              axis_x_nxt.acc_neg = 1'b0;
            end
          endcase
        end
        slvi_pkg::OP_HUMAN: begin
          if (!train_mode_r) begin
            axis_y_nxt.armed   = 1'b1;
            axis_y_nxt.incr    = hv_incr;
            axis_y_nxt.acc_pos = hv_big && !in_q_r.human_value[31];
            axis_y_nxt.acc_neg = hv_big && in_q_r.human_value[31];
          end
        end
        slvi_pkg::OP_TRAIN: begin
          train_mode_nxt = in_q_r.train_on;
        end
        slvi_pkg::OP_RESTART: begin
          axis_x_nxt.armed = 1'b0;
          axis_x_nxt.vel   = '0;
          axis_y_nxt.armed = 1'b0;
          axis_y_nxt.vel   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_q_nxt.velocity_x = train_mode_r ? '0 : axis_x_nxt.vel;
    out_q_nxt.velocity_y = train_mode_r ? '0 : axis_y_nxt.vel;
    out_q_nxt.stopped_x  = axis_x_nxt.stop;
    out_q_nxt.stopped_y  = axis_y_nxt.stop;
    if (proc_ok && is_tick) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_q_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      axis_x_r     <= '0;
      axis_y_r     <= '0;
      train_mode_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_q_valid_r <= in_valid;
      end
      out_valid_r  <= out_valid_nxt;
      axis_x_r     <= axis_x_nxt;
      axis_y_r     <= axis_y_nxt;
      train_mode_r <= train_mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q_r <= in_data;
    end
    if (proc_ok && is_tick) begin
      out_q_r <= out_q_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      lim_x_r <= '0;
      lim_y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        slvi_pkg::REG_VEL_FLOOR: win_r.floor_v <= $signed(cfg_wdata);
        slvi_pkg::REG_VEL_CEIL:  win_r.ceil_v  <= $signed(cfg_wdata);
        slvi_pkg::REG_X_LOWER:   lim_x_r.lo    <= $signed(cfg_wdata);
        slvi_pkg::REG_X_UPPER:   lim_x_r.hi    <= $signed(cfg_wdata);
        slvi_pkg::REG_Y_LOWER:   lim_y_r.lo    <= $signed(cfg_wdata);
        slvi_pkg::REG_Y_UPPER:   lim_y_r.hi    <= $signed(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  `SLVI_ASSERT_NEXT(a_train_zero_out, proc_ok && is_tick && train_mode_r,
    out_valid_r && out_q_r.velocity_x == 32'sd0 && out_q_r.velocity_y == 32'sd0)
  `SLVI_ASSERT_NEXT(a_restart_clears,
    proc_ok && in_q_r.operation == slvi_pkg::OP_RESTART,
    !axis_x_r.armed && !axis_y_r.armed && axis_x_r.vel == 32'sd0 && axis_y_r.vel == 32'sd0)
  `SLVI_ASSERT_NOW(a_stop_zero_vel, $rose(axis_x_r.stop),
    axis_x_r.vel == 32'sd0 && axis_x_r.ticks != '0)
  `SLVI_ASSERT_NEXT(a_tick_held, in_q_valid_r && is_tick && out_valid_r && !out_ready,
    in_q_valid_r && is_tick && out_valid_r)

endmodule

`default_nettype wire

@@ design/slvi_axis.sv @@
// One axis tick: velocity integration, clamping, limit lookahead and stop latch.
`timescale 1ns / 1ps
`default_nettype none

module slvi_axis #(
  parameter int ARM_TICKS = 50
) (
  input  slvi_pkg::axis_st_t  st_i,
  input  logic signed [31:0]  pos,
  input  slvi_pkg::limits_t   lim,
  input  slvi_pkg::window_t   win,
  output slvi_pkg::axis_st_t  st_o
);

  localparam logic [slvi_pkg::TICK_W-1:0] ARM_LIM = ARM_TICKS[slvi_pkg::TICK_W-1:0];

  logic signed [32:0] sum_w;
  logic signed [31:0] vel_c;
  logic [slvi_pkg::TICK_W-1:0] ticks_inc;
  logic signed [33:0] pos2;
  logic signed [33:0] lim_sum;
  logic below;
  logic toward;
  logic signed [40:0] pos100;
  logic signed [40:0] hi_room;
  logic signed [40:0] lo_room;
  logic trip;

  assign sum_w = 33'(st_i.vel) + 33'(st_i.incr);

  always_comb begin
    if (sum_w < 33'(win.floor_v)) begin
      vel_c = win.floor_v;
    end else if (sum_w > 33'(win.ceil_v)) begin
      vel_c = win.ceil_v;
    end else begin
      vel_c = sum_w[31:0];
    end
  end

  assign ticks_inc = (st_i.ticks != slvi_pkg::TICK_SAT) ? st_i.ticks + 1'b1 : st_i.ticks;

  assign pos2    = 34'(pos) <<< 1;
  assign lim_sum = 34'(lim.lo) + 34'(lim.hi);
  assign below   = pos2 < lim_sum;
  assign toward  = below ? st_i.acc_pos : st_i.acc_neg;

  // The lookahead is compared as velocity against the room left before each limit.
  assign pos100  = 41'(pos) * 41'sd100;
  assign hi_room = 41'(lim.hi) * 41'sd100 - pos100;
  assign lo_room = 41'(lim.lo) * 41'sd100 - pos100;
  assign trip    = (41'(vel_c) > hi_room) || (41'(vel_c) < lo_room);

  always_comb begin
    st_o       = st_i;
    st_o.ticks = ticks_inc;
    st_o.vel   = vel_c;
    if (st_i.stop) begin
      st_o.ticks = '0;
      if (toward) begin
        st_o.stop = 1'b0;
      end else begin
        st_o.vel = '0;
      end
    end else if ((ticks_inc > ARM_LIM) && trip) begin
      st_o.vel  = '0;
      st_o.stop = 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the soft-limit velocity integrator, with directed and random items.
`timescale 1ns / 1ps
`default_nettype none

module tb;

  localparam int ARM_TICKS = 50;
  localparam int ACCEL_STEP = 13107;
  localparam int ONE = 65536;
  localparam int MAX_REPORTS = 10;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;
  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;

  typedef struct {
    logic signed [31:0] vel;
    logic signed [31:0] acc;
    logic               armed;
    logic               stop;
    logic [5:0]         ticks;
  } axis_t;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  slvi_pkg::in_t   in_data;
  logic            out_valid;
  logic            out_ready;
  slvi_pkg::out_t  out_data;
  logic            cfg_we;
  logic [2:0]      cfg_index;
  logic [31:0]     cfg_wdata;

  axis_t              axis_x;
  axis_t              axis_y;
  logic               train_q;
  logic signed [31:0] win_floor;
  logic signed [31:0] win_ceil;
  logic signed [31:0] x_lo;
  logic signed [31:0] x_hi;
  logic signed [31:0] y_lo;
  logic signed [31:0] y_hi;
  slvi_pkg::out_t     velocity_q[$];

  bit          idle_en = 1'b1;
  bit          keep_busy = 1'b0;
  int unsigned stall_left = 0;
  int unsigned n_fail = 0;
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_stopped = 0;

  soft_limit_velocity_integrator_unit #(.ARM_TICKS(ARM_TICKS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void report_failure(string msg);
    n_fail++;
    if (n_fail <= MAX_REPORTS) begin
      $display("%0t: %s", $time, msg);
    end
  endfunction

  function automatic void clear_model();
    axis_x = '{vel: 0, acc: 0, armed: 1'b0, stop: 1'b0, ticks: '0};
    axis_y = axis_x;
    train_q = 1'b0;
    win_floor = 0;
    win_ceil = 0;
    x_lo = 0;
    x_hi = 0;
    y_lo = 0;
    y_hi = 0;
  endfunction

  function automatic axis_t advance_axis(axis_t a, logic signed [31:0] pos,
                                         logic signed [31:0] lo, logic signed [31:0] hi);
    longint v;
    longint ahead;
    if (a.ticks != '1) begin
      a.ticks++;
    end
    v = longint'(a.vel) + longint'(a.acc) / 125;
    if (v < win_floor) begin
      v = win_floor;
    end else if (v > win_ceil) begin
      v = win_ceil;
    end
    a.vel = 32'(v);
    if (a.stop) begin
      // A held axis is released only by an acceleration pointing back to the middle.
      if (2 * longint'(pos) < longint'(lo) + longint'(hi)) begin
        if (a.acc <= 0) a.vel = 0;
        else a.stop = 1'b0;
      end else begin
        if (a.acc >= 0) a.vel = 0;
        else a.stop = 1'b0;
      end
      a.ticks = '0;
    end else if (a.ticks > ARM_TICKS) begin
      ahead = 100 * longint'(pos) + longint'(a.vel);
      if (ahead > 100 * longint'(hi) || ahead < 100 * longint'(lo)) begin
        a.vel = 0;
        a.stop = 1'b1;
      end
    end
    return a;
  endfunction

  function automatic void apply_item(slvi_pkg::in_t it);
    slvi_pkg::out_t r;
    case (it.operation)
      slvi_pkg::OP_TICK: begin
        if (!train_q) begin
          if (axis_x.armed) axis_x = advance_axis(axis_x, it.position_x, x_lo, x_hi);
          if (axis_y.armed) axis_y = advance_axis(axis_y, it.position_y, y_lo, y_hi);
          r.velocity_x = axis_x.vel;
          r.velocity_y = axis_y.vel;
        end else begin
          r.velocity_x = 0;
          r.velocity_y = 0;
        end
        r.stopped_x = axis_x.stop;
        r.stopped_y = axis_y.stop;
        velocity_q = {velocity_q, r};
      end
      slvi_pkg::OP_ACTION: begin
        case (it.agent_action)
          slvi_pkg::ACT_POS: axis_x.acc = ACCEL_STEP;
          slvi_pkg::ACT_NEG: axis_x.acc = -ACCEL_STEP;
          default: axis_x.acc = 0;
        endcase
        axis_x.armed = 1'b1;
      end
      slvi_pkg::OP_HUMAN: begin
        if (!train_q) begin
          axis_y.acc = $signed(it.human_value) / 32'sd5;
          axis_y.armed = 1'b1;
        end
      end
      slvi_pkg::OP_TRAIN: train_q = it.train_on;
      slvi_pkg::OP_RESTART: begin
        axis_x.armed = 1'b0;
        axis_y.armed = 1'b0;
        axis_x.vel = 0;
        axis_y.vel = 0;
      end
      default: ;
    endcase
  endfunction

  function automatic slvi_pkg::in_t random_item(logic [2:0] op);
    slvi_pkg::in_t it;
    it.operation = op;
    it.position_x = $urandom();
    it.position_y = $urandom();
    it.agent_action = 2'($urandom());
    it.human_value = $urandom();
    it.train_on = 1'($urandom());
    return it;
  endfunction

  function automatic slvi_pkg::in_t tick_item(logic signed [31:0] px, logic signed [31:0] py);
    slvi_pkg::in_t it;
    it = random_item(slvi_pkg::OP_TICK);
    it.position_x = px;
    it.position_y = py;
    return it;
  endfunction

  function automatic logic signed [31:0] pick_position(logic signed [31:0] lo,
                                                       logic signed [31:0] hi);
    longint a;
    longint b;
    longint p;
    int unsigned roll;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    roll = $urandom_range(0, 9);
    if (roll == 0) begin
      p = longint'(int'($urandom()));
    end else if (roll < 3) begin
      p = b - ONE + longint'($urandom_range(0, 3 * ONE));
    end else if (roll < 5) begin
      p = a + ONE - longint'($urandom_range(0, 3 * ONE));
    end else begin
      p = a + longint'($urandom()) % (b - a + 1);
    end
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    return 32'(p);
  endfunction

  function automatic logic signed [31:0] pick_human();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return int'($urandom_range(0, 20 * ONE)) - 10 * ONE;
    if (roll < 9) return int'($urandom_range(0, 2000 * ONE)) - 1000 * ONE;
    return $urandom();
  endfunction

  task automatic send_item(slvi_pkg::in_t it);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
    apply_item(it);
  endtask

  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (velocity_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic signed [31:0] vmin, logic signed [31:0] vmax,
                           logic signed [31:0] xl, logic signed [31:0] xh,
                           logic signed [31:0] yl, logic signed [31:0] yh);
    logic [31:0] vals [8];
    // The two slots past the last register exercise the unused indexes.
    vals = '{vmin, vmax, xl, xh, yl, yh, $urandom(), $urandom()};
    for (int i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    win_floor = vmin;
    win_ceil = vmax;
    x_lo = xl;
    x_hi = xh;
    y_lo = yl;
    y_hi = yh;
  endtask

  task automatic send_noise(int unsigned count);
    repeat (count) send_item(random_item(3'($urandom())));
  endtask

  // One run from restart: arm both axes, then ticks with occasional new commands.
  task automatic run_episode(int unsigned n_ticks);
    slvi_pkg::in_t it;
    int unsigned roll;
    idle_en = !keep_busy && ($urandom_range(0, 3) != 0);
    it = random_item(slvi_pkg::OP_TRAIN);
    it.train_on = 1'b0;
    send_item(it);
    send_item(random_item(slvi_pkg::OP_RESTART));
    send_item(random_item(slvi_pkg::OP_ACTION));
    it = random_item(slvi_pkg::OP_HUMAN);
    it.human_value = pick_human();
    send_item(it);
    repeat (n_ticks) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        send_item(random_item(slvi_pkg::OP_ACTION));
      end else if (roll < 12) begin
        it = random_item(slvi_pkg::OP_HUMAN);
        it.human_value = pick_human();
        send_item(it);
      end else if (roll < 14) begin
        it = random_item(slvi_pkg::OP_TRAIN);
        it.train_on = ($urandom_range(0, 2) == 0);
        send_item(it);
      end else if (roll < 16) begin
        send_noise(1);
      end else if (roll < 17) begin
        send_item(random_item(slvi_pkg::OP_RESTART));
        send_item(random_item(slvi_pkg::OP_ACTION));
      end else begin
        send_item(tick_item(pick_position(x_lo, x_hi), pick_position(y_lo, y_hi)));
      end
    end
  endtask

  task automatic test_reset_defaults();
    send_noise(30);
    run_episode(55);
  endtask

  task automatic test_directed_edges();
    slvi_pkg::in_t it;
    wait_for_idle();
    idle_en = 1'b1;
    configure(-2 * ONE, 2 * ONE, -4 * ONE, 4 * ONE, -3 * ONE, 3 * ONE);
    send_item(tick_item(Q_MAX, Q_MIN));
    for (int op = int'(slvi_pkg::OP_RESTART) + 1; op < 8; op++) begin
      send_item(random_item(3'(op)));
    end
    // Action code three behaves as no acceleration but still arms the axis.
    it = random_item(slvi_pkg::OP_ACTION);
    it.agent_action = '1;
    send_item(it);
    send_item(tick_item(Q_MIN, Q_MAX));
    it.agent_action = slvi_pkg::ACT_POS;
    send_item(it);
    send_item(tick_item(ONE, -ONE));
    it.agent_action = slvi_pkg::ACT_NEG;
    send_item(it);
    send_item(tick_item(-ONE, ONE));
    it.agent_action = slvi_pkg::ACT_NONE;
    send_item(it);
    send_item(tick_item(0, 0));
    it = random_item(slvi_pkg::OP_HUMAN);
    it.human_value = Q_MAX;
    send_item(it);
    send_item(tick_item(3 * ONE, -3 * ONE));
    it.human_value = Q_MIN;
    send_item(it);
    send_item(tick_item(-4 * ONE, 2 * ONE));
    it = random_item(slvi_pkg::OP_TRAIN);
    it.train_on = 1'b1;
    send_item(it);
    it = random_item(slvi_pkg::OP_HUMAN);
    it.human_value = 5 * ONE;
    send_item(it);
    send_item(tick_item(ONE, ONE));
    it = random_item(slvi_pkg::OP_TRAIN);
    it.train_on = 1'b0;
    send_item(it);
    send_item(tick_item(ONE, ONE));
    send_item(random_item(slvi_pkg::OP_RESTART));
    send_item(tick_item(Q_MAX, Q_MAX));
  endtask

  task automatic test_limit_stops();
    wait_for_idle();
    configure(-3 * ONE, 3 * ONE, -8 * ONE, 8 * ONE, -5 * ONE, 5 * ONE);
    repeat (6) run_episode($urandom_range(60, 110));
    send_noise(60);
  endtask

  task automatic test_wide_window();
    wait_for_idle();
    configure(Q_MIN, Q_MAX, Q_MIN, Q_MAX, -ONE, ONE);
    repeat (2) run_episode($urandom_range(60, 110));
    wait_for_idle();
    configure(Q_MIN, Q_MAX, 0, 0, Q_MIN, Q_MAX);
    run_episode($urandom_range(60, 110));
    send_noise(40);
  endtask

  task automatic test_inverted_window();
    wait_for_idle();
    configure(ONE, -ONE, 4 * ONE, -4 * ONE, 2 * ONE, -2 * ONE);
    repeat (3) run_episode($urandom_range(60, 110));
    send_noise(40);
  endtask

  task automatic test_back_to_back();
    int ceil_v;
    int xh;
    int yh;
    keep_busy = 1'b1;
    idle_en = 1'b0;
    wait_for_idle();
    ceil_v = int'($urandom_range(ONE / 2, 4 * ONE));
    xh = int'($urandom_range(ONE, 20 * ONE));
    yh = int'($urandom_range(ONE, 20 * ONE));
    configure(-ceil_v, ceil_v, -xh, xh, -yh, yh);
    repeat (5) run_episode($urandom_range(60, 110));
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    slvi_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (out_data.stopped_x || out_data.stopped_y) n_stopped++;
      if (velocity_q.size() == 0) begin
        report_failure($sformatf("unexpected result vx=%0d vy=%0d sx=%0b sy=%0b",
                                 out_data.velocity_x, out_data.velocity_y,
                                 out_data.stopped_x, out_data.stopped_y));
      end else begin
        want = velocity_q.pop_front();
        if (out_data.velocity_x !== want.velocity_x || out_data.velocity_y !== want.velocity_y
            || out_data.stopped_x !== want.stopped_x
            || out_data.stopped_y !== want.stopped_y) begin
          report_failure($sformatf(
            "result %0d: expected vx=%0d vy=%0d sx=%0b sy=%0b, got vx=%0d vy=%0d sx=%0b sy=%0b",
            n_results, want.velocity_x, want.velocity_y, want.stopped_x, want.stopped_y,
            out_data.velocity_x, out_data.velocity_y, out_data.stopped_x, out_data.stopped_y));
        end
      end
    end
  end

  initial begin
    in_valid <= 1'b0;
    in_data <= '0;
    out_ready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    clear_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_directed_edges();
    test_limit_stops();
    test_wide_window();
    test_inverted_window();
    test_back_to_back();
    wait_for_idle();
    repeat (10) @(posedge clk);
    if (velocity_q.size() != 0) begin
      report_failure($sformatf("%0d results never arrived", velocity_q.size()));
    end
    $display("Sent %0d items and checked %0d results, %0d of them with an axis held at a limit.",
             n_items, n_results, n_stopped);
    $display("Mismatches or missing results: %0d.", n_fail);
    if (n_fail == 0) begin
      $display("** soft_limit_velocity_integrator_unit: PASSED **");
    end else begin
      $display("** soft_limit_velocity_integrator_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding.", velocity_q.size());
    $display("** soft_limit_velocity_integrator_unit: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
